/* hw/rtl/skt_pkg.sv */
`default_nettype none
package skt_pkg;

    localparam int MAX_ENTRIES     = 32;
    localparam int MAX_VALUE_BYTES = 8;

    localparam int KEY_W  = 16;
    localparam int VAL_W  = 64;
    localparam int VCNT_W = 8;
    localparam int CNT_W  = 4;
    localparam int USED_W = $clog2(MAX_ENTRIES + 1);
    localparam int DATA_W = KEY_W + VAL_W + VCNT_W;
    localparam int RES_W  = KEY_W + 2 + 1 + 1 + VAL_W + CNT_W;

    typedef enum logic [2:0] {
        CMD_POLL  = 3'd0,
        CMD_SUB   = 3'd1,
        CMD_SET   = 3'd2,
        CMD_CLR   = 3'd3,
        CMD_READ  = 3'd4,
        CMD_LIST  = 3'd5,
        CMD_RSV6  = 3'd6,
        CMD_RSV7  = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_HIT  = 2'd0,
        ST_INS  = 2'd1,
        ST_NONE = 2'd2,
        ST_FULL = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LIST
    } t_state;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_INSERT,
        CELL_SETF,
        CELL_CLRF,
        CELL_ROTATE
    } t_cell_op;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [CNT_W-1:0] count;
        logic             flag;
    } t_entry;

    typedef struct packed {
        t_cell_op         op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [CNT_W-1:0] count;
        logic             set_flag;
    } t_cell_ctrl;

    typedef struct packed {
        logic   hit;
        logic   changed;
        logic   more_flag;
        t_entry hit_ent;
        t_entry head_ent;
    } t_chain_stat;

    // packed MSB first, so key lands in the lowest bits of tdata
    typedef struct packed {
        logic [CNT_W-1:0] stored_count;
        logic [VAL_W-1:0] stored_bytes;
        logic             flag_out;
        logic             change_event;
        t_status          status;
        logic [KEY_W-1:0] result_key;
    } t_result;

    function automatic logic [VAL_W-1:0] byte_mask(input logic [CNT_W-1:0] n);
        logic [VAL_W-1:0] m;
        m = '0;
        for (int b = 0; b < VAL_W / 8; b++) begin
            if (CNT_W'(b) < n) begin
                m[8*b +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/skt_cell.sv */
`default_nettype none
module skt_cell (
    input  wire logic                i_clk,
    input  wire skt_pkg::t_cell_ctrl i_ctrl,
    input  wire logic                i_in_use,
    input  wire logic                i_tail,
    input  wire logic                i_prev_lt,
    input  wire skt_pkg::t_entry     i_prev,
    input  wire skt_pkg::t_entry     i_next,
    input  wire skt_pkg::t_entry     i_wrap,
    output skt_pkg::t_entry          o_entry,
    output logic                     o_lt,
    output logic                     o_hit,
    output logic                     o_changed
);
    import skt_pkg::*;

    t_entry r_ent;
    t_entry n_ent;

    assign o_entry   = r_ent;
    assign o_lt      = i_in_use && (r_ent.key < i_ctrl.key);
    assign o_hit     = i_in_use && (r_ent.key == i_ctrl.key);
    // stored and incoming values are both masked to their counts
    assign o_changed = (r_ent.count != i_ctrl.count) || (r_ent.value != i_ctrl.value);

    always_comb begin
        n_ent = r_ent;
        case (i_ctrl.op)
            CELL_WRITE: begin
                if (o_hit) begin
                    n_ent.value = i_ctrl.value;
                    n_ent.count = i_ctrl.count;
                    n_ent.flag  = r_ent.flag | i_ctrl.set_flag;
                end
            end
            CELL_INSERT: begin
                if (!o_lt) begin
                    if (i_prev_lt) begin
                        n_ent.key   = i_ctrl.key;
                        n_ent.value = i_ctrl.value;
                        n_ent.count = i_ctrl.count;
                        n_ent.flag  = 1'b1;
                    end else begin
                        n_ent = i_prev;
                    end
                end
            end
            CELL_SETF: begin
                if (o_hit) n_ent.flag = 1'b1;
            end
            CELL_CLRF: begin
                if (o_hit) n_ent.flag = 1'b0;
            end
            CELL_ROTATE: begin
                if (i_in_use) n_ent = i_tail ? i_wrap : i_next;
            end
            default: begin
                n_ent = r_ent;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

endmodule
`default_nettype wire

/* hw/rtl/skt_chain.sv */
`default_nettype none
module skt_chain (
    input  wire logic                       i_clk,
    input  wire skt_pkg::t_cell_ctrl        i_ctrl,
    input  wire logic [skt_pkg::USED_W-1:0] i_used,
    input  wire logic [skt_pkg::USED_W-1:0] i_remain,
    output skt_pkg::t_chain_stat            o_stat
);
    import skt_pkg::*;

    t_entry w_ent [MAX_ENTRIES];
    logic   w_lt  [MAX_ENTRIES];
    logic   w_hit [MAX_ENTRIES];
    logic   w_chg [MAX_ENTRIES];

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        t_entry w_prev;
        t_entry w_next;
        logic   w_prev_lt;

        if (g == 0) begin : g_first
            assign w_prev    = '0;
            assign w_prev_lt = 1'b1;
        end else begin : g_mid
            assign w_prev    = w_ent[g-1];
            assign w_prev_lt = w_lt[g-1];
        end

        if (g == MAX_ENTRIES - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_ent[g+1];
        end

        skt_cell u_cell (
            .i_clk     (i_clk),
            .i_ctrl    (i_ctrl),
            .i_in_use  (USED_W'(g) < i_used),
            .i_tail    (USED_W'(g + 1) == i_used),
            .i_prev_lt (w_prev_lt),
            .i_prev    (w_prev),
            .i_next    (w_next),
            .i_wrap    (w_ent[0]),
            .o_entry   (w_ent[g]),
            .o_lt      (w_lt[g]),
            .o_hit     (w_hit[g]),
            .o_changed (w_chg[g])
        );
    end

    always_comb begin
        o_stat          = '0;
        o_stat.head_ent = w_ent[0];
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (w_hit[i]) begin
                o_stat.hit     = 1'b1;
                o_stat.changed = o_stat.changed | w_chg[i];
                o_stat.hit_ent = o_stat.hit_ent | w_ent[i];
            end
            // flags still ahead of the head in the rotating walk
            if (i > 0 && USED_W'(i) < i_remain && w_ent[i].flag) begin
                o_stat.more_flag = 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/sorted_keyed_table_with_dirty_flags.sv */
// Channel  Dir  Handshake                    tdata / tuser / tlast
// s_axis   in   s_axis_tvalid/s_axis_tready  tdata: key, value_bytes, value_count
//                                            tuser: command
// m_axis   out  m_axis_tvalid/m_axis_tready  tdata: result_key .. stored_count
//                                            tlast: last
// A non-list item is accepted, then executed in the cell row;
// its result sits in the output register while the next item is accepted.
// A list item on a non-empty table is accepted and executed, then the
// row rotates one cell per cycle unless stalled as below.
// Reset clears the entry count and the handshake state; the cells keep garbage.
// A full output register stalls execution, and the list walk where it must emit.
`default_nettype none
module sorted_keyed_table_with_dirty_flags (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    // [15:0] key, [79:16] value_bytes, [87:80] value_count
    input  wire logic [skt_pkg::DATA_W-1:0] s_axis_tdata,
    // [2:0] command
    input  wire logic [2:0]                 s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // [15:0] result_key, [17:16] status, [18] change_event, [19] flag_out,
    // [83:20] stored_bytes, [87:84] stored_count
    output logic [skt_pkg::RES_W-1:0]       m_axis_tdata,
    output logic                            m_axis_tlast
);
    import skt_pkg::*;

    t_state             r_state, n_state;
    t_cmd               r_cmd;
    logic [KEY_W-1:0]   r_key;
    logic [VAL_W-1:0]   r_value;
    logic [CNT_W-1:0]   r_count;
    logic [USED_W-1:0]  r_used, n_used;
    logic [USED_W-1:0]  r_remain, n_remain;
    logic               r_emitted, n_emitted;
    logic               r_out_valid;
    t_result            r_out, n_out;
    logic               r_out_last, n_out_last;

    logic               w_accept;
    logic               w_slot_free;
    logic               w_load;
    logic [CNT_W-1:0]   w_cnt_sat;
    t_cell_ctrl         w_ctrl;
    t_chain_stat        w_stat;
    logic               w_ev;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_slot_free   = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;
    assign m_axis_tlast  = r_out_last;

    assign w_cnt_sat = (s_axis_tdata[87:80] > VCNT_W'(MAX_VALUE_BYTES))
                     ? CNT_W'(MAX_VALUE_BYTES) : s_axis_tdata[83:80];
    assign w_ev      = (r_cmd == CMD_SUB) || w_stat.changed;

    skt_chain u_chain (
        .i_clk    (i_clk),
        .i_ctrl   (w_ctrl),
        .i_used   (r_used),
        .i_remain (r_remain),
        .o_stat   (w_stat)
    );

    always_comb begin
        n_state    = r_state;
        n_used     = r_used;
        n_remain   = r_remain;
        n_emitted  = r_emitted;
        w_load     = 1'b0;
        n_out      = '0;
        n_out.result_key = r_key;
        n_out.status     = ST_NONE;
        n_out_last = 1'b1;
        w_ctrl          = '0;
        w_ctrl.op       = CELL_HOLD;
        w_ctrl.key      = r_key;
        w_ctrl.value    = r_value;
        w_ctrl.count    = r_count;
        w_ctrl.set_flag = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_slot_free) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                    case (r_cmd)
                        CMD_POLL, CMD_SUB: begin
                            if (w_stat.hit) begin
                                w_ctrl.op          = CELL_WRITE;
                                w_ctrl.set_flag    = w_ev;
                                n_out.status       = ST_HIT;
                                n_out.change_event = w_ev;
                                n_out.flag_out     = w_stat.hit_ent.flag | w_ev;
                            end else if (r_used == USED_W'(MAX_ENTRIES)) begin
                                n_out.status = ST_FULL;
                            end else begin
                                w_ctrl.op          = CELL_INSERT;
                                n_used             = r_used + USED_W'(1);
                                n_out.status       = ST_INS;
                                n_out.change_event = 1'b1;
                                n_out.flag_out     = 1'b1;
                            end
                        end
                        CMD_SET, CMD_CLR: begin
                            if (w_stat.hit) begin
                                w_ctrl.op      = (r_cmd == CMD_SET) ? CELL_SETF : CELL_CLRF;
                                n_out.status   = ST_HIT;
                                n_out.flag_out = (r_cmd == CMD_SET);
                            end
                        end
                        CMD_READ: begin
                            if (w_stat.hit) begin
                                n_out.status       = ST_HIT;
                                n_out.flag_out     = w_stat.hit_ent.flag;
                                n_out.stored_bytes = w_stat.hit_ent.value;
                                n_out.stored_count = w_stat.hit_ent.count;
                            end
                        end
                        CMD_LIST: begin
                            if (r_used == '0) begin
                                n_out.result_key = '0;
                            end else begin
                                w_load    = 1'b0;
                                n_state   = S_LIST;
                                n_remain  = r_used;
                                n_emitted = 1'b0;
                            end
                        end
                        default: begin
                            n_out.status = ST_NONE;
                        end
                    endcase
                end
            end
            S_LIST: begin
                n_out.result_key = w_stat.head_ent.key;
                if (w_stat.head_ent.flag) begin
                    n_out.status   = ST_HIT;
                    n_out.flag_out = 1'b1;
                    n_out_last     = !w_stat.more_flag;
                end else begin
                    n_out.result_key = '0;
                end
                // only a flagged head or the empty-walk marker needs the output slot
                if (w_stat.head_ent.flag || (r_remain == USED_W'(1) && !r_emitted)) begin
                    if (w_slot_free) begin
                        w_load    = 1'b1;
                        n_emitted = 1'b1;
                        w_ctrl.op = CELL_ROTATE;
                    end
                end else begin
                    w_ctrl.op = CELL_ROTATE;
                end
                if (w_ctrl.op == CELL_ROTATE) begin
                    n_remain = r_remain - USED_W'(1);
                    if (r_remain == USED_W'(1)) n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_remain    <= '0;
            r_emitted   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_remain  <= n_remain;
            r_emitted <= n_emitted;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= t_cmd'(s_axis_tuser);
            r_key   <= s_axis_tdata[15:0];
            r_count <= w_cnt_sat;
            r_value <= s_axis_tdata[79:16] & byte_mask(w_cnt_sat);
        end
        if (w_load) begin
            r_out      <= n_out;
            r_out_last <= n_out_last;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/skt_checker.sv */
`default_nettype none
module skt_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       m_axis_tvalid,
    input wire logic                       m_axis_tready,
    input wire logic [skt_pkg::RES_W-1:0]  m_axis_tdata,
    input wire logic                       m_axis_tlast
);
    import skt_pkg::*;

    // hold a result until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // only listing produces non-final items, and those are flagged hits
    a_list_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |->
        m_axis_tdata[17:16] == ST_HIT && m_axis_tdata[19] && !m_axis_tdata[18])
        else $error("non-final item is not a flagged listing entry");

    a_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[17:16] == ST_FULL |->
        m_axis_tdata[19:18] == 2'b00 && m_axis_tlast)
        else $error("dropped update reports a flag or event");

    a_inserted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[17:16] == ST_INS |->
        m_axis_tdata[19:18] == 2'b11 && m_axis_tdata[87:84] == '0)
        else $error("insert without flag and event");

endmodule

bind sorted_keyed_table_with_dirty_flags skt_checker u_skt_checker (.*);
`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
    import skt_pkg::*;

    typedef struct {
        logic [KEY_W-1:0] key;
        t_status          status;
        logic             change;
        logic             flag;
        logic [VAL_W-1:0] bytes;
        logic [CNT_W-1:0] count;
        logic             last;
    } t_table_reply;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // [15:0] key, [79:16] value_bytes, [87:80] value_count
    logic [DATA_W-1:0]   s_axis_tdata = '0;
    // [2:0] command
    logic [2:0]          s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // [15:0] result_key, [17:16] status, [18] change_event, [19] flag_out,
    // [83:20] stored_bytes, [87:84] stored_count
    logic [RES_W-1:0]    m_axis_tdata;
    logic                m_axis_tlast;

    // shadow copy of the table, kept in ascending key order
    logic [KEY_W-1:0]    shadow_key  [MAX_ENTRIES];
    logic [VAL_W-1:0]    shadow_val  [MAX_ENTRIES];
    logic [CNT_W-1:0]    shadow_cnt  [MAX_ENTRIES];
    logic                shadow_flag [MAX_ENTRIES];
    int                  shadow_used = 0;

    t_table_reply        expected_replies[$];

    int  error_count     = 0;
    int  items_sent      = 0;
    int  replies_seen    = 0;
    int  list_walks      = 0;
    int  dropped_inserts = 0;
    bit  send_gaps       = 1'b1;
    bit  recv_stalls     = 1'b1;

    sorted_keyed_table_with_dirty_flags dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [VAL_W-1:0] count_mask(input int n);
        if (n >= 8) begin
            return '1;
        end
        return (64'h1 << (8 * n)) - 64'h1;
    endfunction

    // first slot whose key is not below k
    function automatic int find_slot(input logic [KEY_W-1:0] k);
        for (int i = 0; i < shadow_used; i++) begin
            if (shadow_key[i] >= k) begin
                return i;
            end
        end
        return shadow_used;
    endfunction

    function automatic bit key_present(input logic [KEY_W-1:0] k);
        int pos;
        pos = find_slot(k);
        return pos < shadow_used && shadow_key[pos] == k;
    endfunction

    function automatic void push_reply(input logic [KEY_W-1:0] k, input t_status st,
                                       input logic ch, input logic fl,
                                       input logic [VAL_W-1:0] b, input logic [CNT_W-1:0] c,
                                       input logic l);
        t_table_reply r;
        r.key    = k;
        r.status = st;
        r.change = ch;
        r.flag   = fl;
        r.bytes  = b;
        r.count  = c;
        r.last   = l;
        expected_replies = {expected_replies, r};
    endfunction

    function automatic void predict_table_step(input t_cmd cmd, input logic [KEY_W-1:0] k,
                                               input logic [VAL_W-1:0] bytes,
                                               input logic [VCNT_W-1:0] raw_cnt);
        int               cnt;
        int               pos;
        bit               hit;
        bit               changed;
        int               flagged;
        int               listed;
        logic [VAL_W-1:0] v;
        cnt = (raw_cnt > MAX_VALUE_BYTES) ? MAX_VALUE_BYTES : int'(raw_cnt);
        pos = find_slot(k);
        hit = pos < shadow_used && shadow_key[pos] == k;
        case (cmd)
            CMD_POLL, CMD_SUB: begin
                v = bytes & count_mask(cnt);
                if (hit) begin
                    changed = shadow_cnt[pos] != cnt ||
                              ((shadow_val[pos] ^ v) & count_mask(cnt)) != '0;
                    changed = changed || cmd == CMD_SUB;
                    shadow_val[pos] = v;
                    shadow_cnt[pos] = CNT_W'(cnt);
                    if (changed) begin
                        shadow_flag[pos] = 1'b1;
                    end
                    push_reply(k, ST_HIT, changed, shadow_flag[pos], '0, '0, 1'b1);
                end else if (shadow_used >= MAX_ENTRIES) begin
                    dropped_inserts++;
                    push_reply(k, ST_FULL, 1'b0, 1'b0, '0, '0, 1'b1);
                end else begin
                    for (int i = shadow_used; i > pos; i--) begin
                        shadow_key[i]  = shadow_key[i-1];
                        shadow_val[i]  = shadow_val[i-1];
                        shadow_cnt[i]  = shadow_cnt[i-1];
                        shadow_flag[i] = shadow_flag[i-1];
                    end
                    shadow_key[pos]  = k;
                    shadow_val[pos]  = v;
                    shadow_cnt[pos]  = CNT_W'(cnt);
                    shadow_flag[pos] = 1'b1;
                    shadow_used++;
                    push_reply(k, ST_INS, 1'b1, 1'b1, '0, '0, 1'b1);
                end
            end
            CMD_SET, CMD_CLR: begin
                if (!hit) begin
                    push_reply(k, ST_NONE, 1'b0, 1'b0, '0, '0, 1'b1);
                end else begin
                    shadow_flag[pos] = (cmd == CMD_SET);
                    push_reply(k, ST_HIT, 1'b0, shadow_flag[pos], '0, '0, 1'b1);
                end
            end
            CMD_READ: begin
                if (!hit) begin
                    push_reply(k, ST_NONE, 1'b0, 1'b0, '0, '0, 1'b1);
                end else begin
                    push_reply(k, ST_HIT, 1'b0, shadow_flag[pos],
                               shadow_val[pos] & count_mask(shadow_cnt[pos]),
                               shadow_cnt[pos], 1'b1);
                end
            end
            CMD_LIST: begin
                list_walks++;
                flagged = 0;
                listed  = 0;
                for (int i = 0; i < shadow_used; i++) begin
                    flagged += shadow_flag[i];
                end
                if (flagged == 0) begin
                    push_reply('0, ST_NONE, 1'b0, 1'b0, '0, '0, 1'b1);
                end
                for (int i = 0; i < shadow_used; i++) begin
                    if (shadow_flag[i]) begin
                        listed++;
                        push_reply(shadow_key[i], ST_HIT, 1'b0, 1'b1, '0, '0,
                                   listed == flagged);
                    end
                end
            end
            default: begin
                push_reply(k, ST_NONE, 1'b0, 1'b0, '0, '0, 1'b1);
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [63:0] got,
                                        input logic [63:0] want);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endfunction

    always @(negedge i_clk) begin
        m_axis_tready <= !recv_stalls || ($urandom_range(99) >= 27);
    end

    always @(posedge i_clk) begin : reply_check
        t_result      got;
        t_table_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata);
            replies_seen++;
            if (expected_replies.size() == 0) begin
                $error("unexpected reply: result_key %0h, status %0d", got.result_key,
                       got.status);
                error_count++;
            end else begin
                want = expected_replies.pop_front();
                check_field("result_key", got.result_key, want.key);
                check_field("status", got.status, want.status);
                check_field("change_event", got.change_event, want.change);
                check_field("flag_out", got.flag_out, want.flag);
                check_field("stored_bytes", got.stored_bytes, want.bytes);
                check_field("stored_count", got.stored_count, want.count);
                check_field("last", m_axis_tlast, want.last);
            end
        end
    end

    task automatic send_item(input t_cmd cmd, input logic [KEY_W-1:0] k,
                             input logic [VAL_W-1:0] bytes, input logic [VCNT_W-1:0] cnt);
        @(negedge i_clk);
        // idle with junk on the bus
        while (send_gaps && $urandom_range(99) < 27) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= DATA_W'({$urandom, $urandom, $urandom});
            s_axis_tuser  <= 3'($urandom);
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cnt, bytes, k};
        s_axis_tuser  <= cmd;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        predict_table_step(cmd, k, bytes, cnt);
        items_sent++;
    endtask

    // hold the sender until every pending reply is back
    task automatic drain_replies(input int settle);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_replies.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (settle) @(posedge i_clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 55 && shadow_used > 0) begin
            return shadow_key[$urandom_range(shadow_used - 1)];
        end
        if (r < 85) begin
            return KEY_W'($urandom_range(47) * 1361 + 7);
        end
        return KEY_W'($urandom);
    endfunction

    function automatic logic [KEY_W-1:0] absent_key();
        logic [KEY_W-1:0] k;
        k = KEY_W'($urandom);
        while (key_present(k)) begin
            k = KEY_W'($urandom);
        end
        return k;
    endfunction

    task automatic send_random_item();
        int                r;
        int                pos;
        t_cmd              cmd;
        logic [KEY_W-1:0]  k;
        logic [VAL_W-1:0]  bytes;
        logic [VCNT_W-1:0] cnt;
        r = $urandom_range(99);
        if (r < 30)      cmd = CMD_POLL;
        else if (r < 45) cmd = CMD_SUB;
        else if (r < 55) cmd = CMD_SET;
        else if (r < 70) cmd = CMD_CLR;
        else if (r < 85) cmd = CMD_READ;
        else if (r < 93) cmd = CMD_LIST;
        else             cmd = $urandom_range(1) ? CMD_RSV7 : CMD_RSV6;
        k     = pick_key();
        bytes = {$urandom, $urandom};
        cnt   = ($urandom_range(99) < 70) ? VCNT_W'($urandom_range(8)) : VCNT_W'($urandom);
        // resend the stored value so a poll sees no change; junk past the count
        if (cmd == CMD_POLL && $urandom_range(99) < 40) begin
            pos = find_slot(k);
            if (pos < shadow_used && shadow_key[pos] == k) begin
                bytes = (shadow_val[pos] & count_mask(shadow_cnt[pos])) |
                        (bytes & ~count_mask(shadow_cnt[pos]));
                cnt = VCNT_W'(shadow_cnt[pos]);
                if (shadow_cnt[pos] == MAX_VALUE_BYTES && $urandom_range(1)) begin
                    cnt = VCNT_W'($urandom_range(255, MAX_VALUE_BYTES));
                end
            end
        end
        send_item(cmd, k, bytes, cnt);
    endtask

    task automatic test_directed();
        send_item(CMD_LIST, 16'h0000, '0, 8'd0);
        send_item(CMD_READ, 16'h1234, '1, 8'd8);
        send_item(CMD_SET, 16'hFFFF, '0, 8'd0);
        send_item(CMD_CLR, 16'h0000, '0, 8'd0);
        // count saturates to the full eight bytes
        send_item(CMD_POLL, 16'h8000, '1, 8'hFF);
        send_item(CMD_SUB, 16'h0000, 64'hA5A5_5A5A_C3C3_3C3C, 8'd0);
        send_item(CMD_POLL, 16'hFFFF, 64'h0123_4567_89AB_CDEF, 8'd8);
        send_item(CMD_CLR, 16'hFFFF, '0, 8'd0);
        send_item(CMD_POLL, 16'hFFFF, 64'h0123_4567_89AB_CDEF, 8'd8);
        send_item(CMD_POLL, 16'hFFFF, 64'h0123_4567_89AB_CDEF, 8'd200);
        send_item(CMD_POLL, 16'hFFFF, 64'h0123_4567_89AB_CDEE, 8'd8);
        // bytes past a zero count are ignored, then a count change alone
        send_item(CMD_CLR, 16'h0000, '0, 8'd0);
        send_item(CMD_POLL, 16'h0000, 64'hFFFF_0000_FFFF_0000, 8'd0);
        send_item(CMD_POLL, 16'h0000, 64'h0000_0000_0000_0000, 8'd1);
        send_item(CMD_CLR, 16'h8000, '0, 8'd0);
        send_item(CMD_SUB, 16'h8000, '1, 8'd8);
        send_item(CMD_POLL, 16'h4000, '1, 8'd3);
        send_item(CMD_READ, 16'h4000, '0, 8'd0);
        send_item(CMD_READ, 16'h8000, '0, 8'd0);
        send_item(CMD_READ, 16'h0000, '0, 8'd0);
        send_item(CMD_SET, 16'h0000, '0, 8'd0);
        send_item(CMD_LIST, 16'hFFFF, '1, 8'hFF);
        send_item(CMD_RSV6, 16'hABCD, 64'h5555_AAAA_5555_AAAA, 8'd4);
        send_item(CMD_RSV7, 16'h5555, '1, 8'hFF);
    endtask

    task automatic test_random_traffic(input int n);
        repeat (n) send_random_item();
    endtask

    task automatic test_back_to_back(input int n);
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        repeat (n) send_random_item();
        drain_replies(4);
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
    endtask

    task automatic test_table_full();
        logic [KEY_W-1:0] keys[MAX_ENTRIES];
        while (shadow_used < MAX_ENTRIES) begin
            send_item(CMD_SUB, absent_key(), {$urandom, $urandom}, VCNT_W'($urandom));
        end
        send_item(CMD_POLL, absent_key(), {$urandom, $urandom}, 8'd8);
        send_item(CMD_SUB, absent_key(), {$urandom, $urandom}, 8'd2);
        send_item(CMD_READ, absent_key(), '0, 8'd0);
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            keys[i] = shadow_key[i];
        end
        // longest walk: every entry flagged
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            send_item(CMD_SET, keys[i], '0, 8'd0);
        end
        send_item(CMD_LIST, 16'h0000, '0, 8'd0);
        // full table with nothing flagged
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            send_item(CMD_CLR, keys[i], '0, 8'd0);
        end
        send_item(CMD_LIST, 16'h0000, '0, 8'd0);
        send_item(CMD_SUB, keys[0], {$urandom, $urandom}, 8'd8);
        send_item(CMD_READ, keys[0], '0, 8'd0);
        send_item(CMD_LIST, 16'h0000, '0, 8'd0);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        drain_replies(4);
        test_random_traffic(190);
        drain_replies(4);
        test_back_to_back(80);
        test_table_full();
        drain_replies(2 * MAX_ENTRIES + 8);
        $display("Sent %0d items over all commands, reserved codes and saturated counts;",
                 items_sent);
        $display("checked %0d replies, %0d list walks, %0d inserts dropped, %0d entries held.",
                 replies_seen, list_walks, dropped_inserts, shadow_used);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $error("timeout with %0d replies pending", expected_replies.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
